// ===== rtl/delimited_field_extractor_macros.svh =====
// Assertion macros for the delimited field extractor; bodies vanish for synthesis.
`ifndef DELIMITED_FIELD_EXTRACTOR_MACROS_SVH
`define DELIMITED_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DFE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfe assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfe assertion failed");
`else
`define DFE_ASSERT_NOW(label, ante, cons)
`define DFE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/dfe_pkg.sv =====
// Types and constants shared by the delimited field extractor modules.
`timescale 1ns / 1ps
package dfe_pkg;

	localparam int MAX_OUT_LEN = 256;

	// Length cap ceiling: MAX_OUT_LEN-1, never above 255.
	localparam logic [8:0] CAP_LIMIT = 9'((MAX_OUT_LEN - 1 > 255) ? 255 : MAX_OUT_LEN - 1);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] LEAD_MIN = 8'h80;

	typedef enum logic [1:0] {
		REG_DELIMITER    = 2'd0,
		REG_FIELD_NUMBER = 2'd1,
		REG_BUFFER_SIZE  = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		PH_SKIP    = 2'd0,
		PH_EXTRACT = 2'd1,
		PH_DONE    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [6:0] delimiter;
		logic [7:0] field_number;
		logic [8:0] buffer_size;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_status;
		logic       found;
		logic [7:0] field_length;
		logic       last;
	} result_t;

	// Up to two results per request, written into the queue together.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== rtl/dfe_core.sv =====
// Per-byte field extraction logic: string state and result formation.
`timescale 1ns / 1ps
`include "delimited_field_extractor_macros.svh"
module dfe_core import dfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	input  cfg_t       cfg,
	output push_t      push
);

	phase_t     phase_q, phase_d;
	logic [7:0] fields_passed_q, fields_passed_d;
	logic       lead_pending_q, lead_pending_d;
	logic [7:0] held_lead_q, held_lead_d;
	logic [7:0] bytes_out_q, bytes_out_d;
	logic       at_field_start_q, at_field_start_d;

	logic [8:0] cap_raw;
	logic [7:0] cap;
	logic       bs_zero, is_lead, is_delim, before_field;
	logic       full, pair_nofit, do_extract, emit_pair, emit_one;

	// Cap = min(buffer_size-1, CAP_LIMIT); only used when buffer_size != 0
	assign cap_raw      = cfg.buffer_size - 9'd1;
	assign cap          = (cap_raw > CAP_LIMIT) ? CAP_LIMIT[7:0] : cap_raw[7:0];
	assign bs_zero      = (cfg.buffer_size == 9'd0);
	assign is_lead      = (data_byte >= LEAD_MIN);
	assign is_delim     = (data_byte == {1'b0, cfg.delimiter});
	assign before_field = (fields_passed_q < cfg.field_number);
	assign full         = (bytes_out_q >= cap);
	assign pair_nofit   = (({1'b0, bytes_out_q} + 9'd1) >= {1'b0, cap});

	// Extraction runs in EXTRACT, or on the byte that opens the field
	assign do_extract = fire && !end_of_string && !bs_zero &&
		((phase_q == PH_EXTRACT) ||
		 ((phase_q == PH_SKIP) && !lead_pending_q && !before_field));
	assign emit_pair  = do_extract && lead_pending_q && !pair_nofit;
	assign emit_one   = do_extract && !lead_pending_q && !full && !is_lead && !is_delim;

	always_comb begin : next_state
		phase_d          = phase_q;
		fields_passed_d  = fields_passed_q;
		lead_pending_d   = lead_pending_q;
		held_lead_d      = held_lead_q;
		bytes_out_d      = bytes_out_q;
		at_field_start_d = at_field_start_q;
		if (fire && end_of_string) begin
			phase_d          = PH_SKIP;
			fields_passed_d  = 8'd1;
			lead_pending_d   = 1'b0;
			bytes_out_d      = 8'd0;
			at_field_start_d = 1'b0;
		end else if (fire && !bs_zero) begin
			case (phase_q)
				PH_SKIP: begin
					if (lead_pending_q) begin
						lead_pending_d = 1'b0;
					end else if (before_field) begin
						if (is_lead) begin
							lead_pending_d = 1'b1;
							held_lead_d    = data_byte;
						end else if (is_delim) begin
							fields_passed_d = fields_passed_q + 8'd1;
						end
					end else begin
						phase_d          = PH_EXTRACT;
						at_field_start_d = 1'b1;
					end
				end
				PH_EXTRACT, PH_DONE: ;
				default: ;
			endcase
			if (do_extract) begin
				if (lead_pending_q) begin
					lead_pending_d = 1'b0;
					if (pair_nofit) begin
						phase_d = PH_DONE;
					end else begin
						bytes_out_d = bytes_out_q + 8'd2;
					end
				end else if (full || (!is_lead && is_delim)) begin
					phase_d = PH_DONE;
				end else if (is_lead) begin
					lead_pending_d = 1'b1;
					held_lead_d    = data_byte;
				end else begin
					bytes_out_d = bytes_out_q + 8'd1;
				end
			end
		end
	end

	always_comb begin : outputs
		push = '0;
		if (fire && end_of_string) begin
			push.count           = 2'd1;
			push.r0.is_status    = 1'b1;
			push.r0.last         = 1'b1;
			push.r0.found        = !bs_zero &&
				(at_field_start_q || ((phase_q == PH_SKIP) && lead_pending_q));
			push.r0.field_length = bs_zero ? 8'd0 : bytes_out_q;
		end else if (emit_pair) begin
			push.count       = 2'd2;
			push.r0.out_byte = held_lead_q;
			push.r1.out_byte = data_byte;
		end else if (emit_one) begin
			push.count       = 2'd1;
			push.r0.out_byte = data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_SKIP;
			fields_passed_q  <= 8'd1;
			lead_pending_q   <= 1'b0;
			bytes_out_q      <= 8'd0;
			at_field_start_q <= 1'b0;
		end else begin
			phase_q          <= phase_d;
			fields_passed_q  <= fields_passed_d;
			lead_pending_q   <= lead_pending_d;
			bytes_out_q      <= bytes_out_d;
			at_field_start_q <= at_field_start_d;
		end
	end

	always_ff @(posedge clk) begin
		held_lead_q <= held_lead_d;
	end

	// A pair only leaves from EXTRACT with a lead held
	`DFE_ASSERT_NOW(a_pair_src, push.count == 2'd2, lead_pending_q && (phase_q == PH_EXTRACT))
	// Terminator restarts the string
	`DFE_ASSERT_NEXT(a_eos_reset, fire && end_of_string,
		(phase_q == PH_SKIP) && (bytes_out_q == 8'd0) && !at_field_start_q)
	// Bytes are only counted once the field is reached
	`DFE_ASSERT_NOW(a_count_field, bytes_out_q != 8'd0, at_field_start_q)

endmodule

// ===== rtl/dfe_out_fifo.sv =====
// Small result queue decoupling the extraction stage from the result channel.
`timescale 1ns / 1ps
`include "delimited_field_extractor_macros.svh"
module dfe_out_fifo import dfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [CNT_W-1:0]  count_q;
	logic              pop;

	assign room      = (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign wr_ptr_p1 = wr_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	`DFE_ASSERT_NOW(a_no_overflow, push.count != 2'd0, room)
	`DFE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(FIFO_DEPTH))

endmodule

// ===== rtl/delimited_field_extractor.sv =====
// Top level of the delimited field extractor: request register, registers, queue.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  byte     | byte_valid, byte_stall, data_byte, end_of_string | in
//  result   | result_valid, result_stall, out_byte, ...        | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data        | in
//
// One byte request per cycle while byte_stall is low; a request is registered,
// then processed in one pass that pushes 0, 1 or 2 results into a four-entry
// result queue. A double-byte pair yields two results, so the result port's
// one-per-cycle drain, while result_stall is low, sets the rate there.
// Reset (arst_n low) clears the string state, the queue and loads the
// register defaults: delimiter '|', field 1, buffer size 256.
// byte_stall rises while a request is held and the queue lacks room for two
// more results.
`timescale 1ns / 1ps
`include "delimited_field_extractor_macros.svh"
module delimited_field_extractor import dfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// byte channel
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_string,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic       found,
	output logic [7:0] field_length,
	output logic       last,
	// register writes
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       eos_s1;
	logic       room, advance, accept;
	push_t      push;
	result_t    head;

	// Registers are always writable; the user lets writes land only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delimiter    <= 7'd124;
			cfg_q.field_number <= 8'd1;
			cfg_q.buffer_size  <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_DELIMITER:    cfg_q.delimiter    <= cfg_data[6:0];
				REG_FIELD_NUMBER: cfg_q.field_number <= cfg_data[7:0];
				REG_BUFFER_SIZE:  cfg_q.buffer_size  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Request register: holds while the queue cannot take two more results
	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1 <= data_byte;
			eos_s1       <= end_of_string;
		end
	end

	dfe_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.data_byte     (data_byte_s1),
		.end_of_string (eos_s1),
		.cfg           (cfg_q),
		.push          (push)
	);

	dfe_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (head)
	);

	assign out_byte     = head.out_byte;
	assign is_status    = head.is_status;
	assign found        = head.found;
	assign field_length = head.field_length;
	assign last         = head.last;

	// A stalled request stays in the register
	`DFE_ASSERT_NEXT(a_s1_hold, valid_s1 && !room, valid_s1)
	// A terminator always produces its status result
	`DFE_ASSERT_NOW(a_eos_status, advance && eos_s1, push.count == 2'd1)

endmodule
